/* hdl/bldc_pkg.sv */
`default_nettype none

package bldc_pkg;

    // Field widths
    localparam int DUTY_W   = 16;
    localparam int SUM_W    = 19;
    localparam int CNT_W    = 3;
    localparam int ACC_W    = 26;
    localparam int ACC_FRAC = 10;

    // Ramp steps, speed scale, averaging and filter gain
    localparam int          STEP_SMALL      = 1;
    localparam int          STEP_MID        = 2;
    localparam int          STEP_LARGE      = 4;
    localparam logic [31:0] SPEED_SCALE     = 32'd1000000;
    localparam int          AVG_SAMPLES     = 6;
    localparam int          FILTER_GAIN_Q10 = 61;

    // Shared divider sizing: numerator covers the speed scale and the interval sum
    localparam int SCALE_W   = $clog2(64'(SPEED_SCALE) + 64'd1);
    localparam int DIV_NUM_W = (SCALE_W > SUM_W) ? SCALE_W : SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Filter arithmetic: signed difference times signed gain
    localparam int DIFF_W = DUTY_W + ACC_FRAC + 1;
    localparam int GAIN_W = $clog2(FILTER_GAIN_Q10 + 1) + 1;
    localparam int PROD_W = DIFF_W + GAIN_W;

    // Signed working width of the duty ramp (steps up to 4)
    localparam int ND_W = DUTY_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_DUTY   = 4'd0,
        CFG_DUTY_MIN      = 4'd1,
        CFG_DUTY_MAX      = 4'd2,
        CFG_THR_LOW       = 4'd3,
        CFG_THR_MID       = 4'd4,
        CFG_THR_HIGH      = 4'd5,
        CFG_LOW_TICKS     = 4'd6,
        CFG_HIGH_TICKS    = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DUTY_W-1:0] target_duty;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_threshold_low;
        logic [DUTY_W-1:0] duty_threshold_mid;
        logic [DUTY_W-1:0] duty_threshold_high;
        logic [DUTY_W-1:0] low_step_ticks;
        logic [DUTY_W-1:0] high_step_ticks;
    } cfg_t;

    // Request payloads
    typedef struct packed {
        logic              op;
        logic [DUTY_W-1:0] interval;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_out;
        logic [DUTY_W-1:0] filtered_speed;
        logic [DUTY_W-1:0] period_estimate;
        logic              average_ready;
    } out_item_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILT_MUL,
        ST_FILT_ADD,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* hdl/bldc_div.sv */
`default_nettype none

module bldc_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [bldc_pkg::DIV_NUM_W-1:0] numer,
    input  wire logic [bldc_pkg::DUTY_W-1:0]    denom,
    output bldc_pkg::div_stat_t                 stat,
    output logic [bldc_pkg::DIV_NUM_W-1:0]      quot
);
    import bldc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DUTY_W-1:0]    rem_reg;
    logic [DUTY_W-1:0]    den_reg;

    logic [DUTY_W:0] rem_sh;
    logic [DUTY_W:0] rem_diff;
    logic            fits;

    // One restoring step: bring down the next numerator bit and try a subtract.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        fits     = (rem_sh >= {1'b0, den_reg});
    end

    // Step counter and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient shifts in from the right as numerator bits leave on the left.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DUTY_W-1:0] : rem_sh[DUTY_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

`default_nettype wire

/* hdl/bldc_ramp.sv */
`default_nettype none

module bldc_ramp (
    input  wire logic [bldc_pkg::DUTY_W-1:0] duty,
    input  wire logic [bldc_pkg::DUTY_W-1:0] tick_count,
    input  wire bldc_pkg::cfg_t              cfg,
    output logic [bldc_pkg::DUTY_W-1:0]      duty_new,
    output logic [bldc_pkg::DUTY_W-1:0]      tick_new
);
    import bldc_pkg::*;

    localparam logic signed [ND_W-1:0] DUTY_TOP = ND_W'((2 ** DUTY_W) - 1);

    logic [DUTY_W-1:0]      tick_inc;
    logic [DUTY_W-1:0]      gate;
    logic signed [ND_W-1:0] duty_ext;
    logic signed [ND_W-1:0] min_ext;
    logic signed [ND_W-1:0] max_ext;
    logic signed [ND_W-1:0] step;
    logic signed [ND_W-1:0] nd;

    // One control tick of the duty ramp, with start-up branch and final clamp.
    always_comb
    begin
        tick_inc = tick_count + 1'b1;
        duty_ext = signed'({2'b00, duty});
        min_ext  = signed'({2'b00, cfg.duty_min});
        max_ext  = signed'({2'b00, cfg.duty_max});
        step     = '0;
        gate     = '0;
        nd       = duty_ext;
        tick_new = tick_inc;
        duty_new = duty;

        if (duty < cfg.duty_min)
        begin
            // Start-up: small steps up to the minimum, saturating, no clamp.
            if (tick_inc > cfg.low_step_ticks)
            begin
                tick_new = '0;
                nd       = duty_ext + ND_W'(STEP_SMALL);
                duty_new = (nd > DUTY_TOP) ? '1 : nd[DUTY_W-1:0];
            end
        end
        else
        begin
            if (duty < cfg.target_duty)
            begin
                // Step size and tick gate depend on the duty band.
                if (duty <= cfg.duty_threshold_low)
                begin
                    step = ND_W'(STEP_SMALL);
                    gate = cfg.low_step_ticks;
                end
                else if (duty > cfg.duty_threshold_mid && duty < cfg.duty_threshold_high)
                begin
                    step = ND_W'(STEP_MID);
                    gate = cfg.high_step_ticks;
                end
                else
                begin
                    step = ND_W'(STEP_LARGE);
                    gate = cfg.high_step_ticks;
                end
                if (tick_inc > gate)
                begin
                    tick_new = '0;
                    nd       = duty_ext + step;
                end
            end
            else
            begin
                tick_new = '0;
                nd       = duty_ext - ND_W'(STEP_MID);
            end

            // Clamp: the lower limit wins over the upper one.
            if (nd <= min_ext)
            begin
                duty_new = cfg.duty_min;
            end
            else if (nd >= max_ext)
            begin
                duty_new = cfg.duty_max;
            end
            else
            begin
                duty_new = nd[DUTY_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bldc_open_loop_duty_ramp_core.sv */
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data   (op, interval)
// out       output     out_valid/out_stall out_data  (duty, speed, period, ready)
// cfg       input      cfg_we              cfg_index, cfg_data
//
// An interval request goes straight to the finish state, or through the shared
// 20-step restoring divider when it closes a group of six. A control tick goes
// through the divider, then one multiply and one add of the speed filter; with a
// zero period it skips the divider. in_stall is high from acceptance until the
// result is loaded into the output register, which holds it while out_stall is
// high. Reset clears control and model state; payload registers are not reset.
`default_nettype none

module bldc_open_loop_duty_ramp_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire bldc_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output bldc_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [bldc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bldc_pkg::DUTY_W-1:0]    cfg_data
);
    import bldc_pkg::*;

    state_t state_reg;
    state_t state_next;

    cfg_t               cfg_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic [DUTY_W-1:0]  tick_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [DUTY_W-1:0]  period_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               avg_valid_reg;
    logic               out_valid_reg;
    logic               op_reg;
    logic [DUTY_W-1:0]  raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    out_item_t          out_data_reg;

    logic               take;
    logic               iv_take;
    logic               tick_take;
    logic               div_start;
    logic               div_take;
    logic               out_load;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   count_new;
    logic               avg_due;
    logic [DIV_NUM_W-1:0] div_numer;
    logic [DUTY_W-1:0]  div_denom;
    logic [DIV_NUM_W-1:0] div_quot;
    div_stat_t          div_stat;
    logic [DUTY_W-1:0]  ramp_duty;
    logic [DUTY_W-1:0]  ramp_tick;
    logic signed [DIFF_W-1:0] diff;
    logic [ACC_W-1:0]   delta;

    // Shared divider: six-sample average and speed scale over period.
    bldc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Duty ramp step for a control tick.
    bldc_ramp u_ramp (
        .duty       (duty_reg),
        .tick_count (tick_reg),
        .cfg        (cfg_reg),
        .duty_new   (ramp_duty),
        .tick_new   (ramp_tick)
    );

    // Interval bookkeeping and filter arithmetic.
    always_comb
    begin
        sum_new   = sum_reg + SUM_W'(in_data.interval);
        count_new = count_reg + 1'b1;
        avg_due   = (count_new >= CNT_W'(AVG_SAMPLES));
        diff      = signed'({1'b0, raw_reg, {ACC_FRAC{1'b0}}}) - signed'(DIFF_W'(acc_reg));
        delta     = ACC_W'(prod_reg >>> ACC_FRAC);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op)
                    begin
                        state_next = (period_reg != '0) ? ST_DIV : ST_FILT_MUL;
                    end
                    else
                    begin
                        state_next = avg_due ? ST_DIV : ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = op_reg ? ST_FILT_MUL : ST_FINISH;
                end
            end
            ST_FILT_MUL: state_next = ST_FILT_ADD;
            ST_FILT_ADD: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control strobes from the state.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        take      = (state_reg == ST_IDLE) && in_valid;
        iv_take   = take && !in_data.op;
        tick_take = take && in_data.op;
        div_start = (iv_take && avg_due) || (tick_take && (period_reg != '0));
        div_numer = in_data.op ? DIV_NUM_W'(SPEED_SCALE) : DIV_NUM_W'(sum_new);
        div_denom = in_data.op ? period_reg : DUTY_W'(AVG_SAMPLES);
        div_take  = (state_reg == ST_DIV) && div_stat.done;
        out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    end

    // Control and model state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= ST_IDLE;
            cfg_reg.target_duty         <= '0;
            cfg_reg.duty_min            <= '0;
            cfg_reg.duty_max            <= '1;
            cfg_reg.duty_threshold_low  <= '0;
            cfg_reg.duty_threshold_mid  <= '0;
            cfg_reg.duty_threshold_high <= '1;
            cfg_reg.low_step_ticks      <= '0;
            cfg_reg.high_step_ticks     <= '0;
            duty_reg                    <= '0;
            tick_reg                    <= '0;
            acc_reg                     <= '0;
            period_reg                  <= '0;
            sum_reg                     <= '0;
            count_reg                   <= '0;
            avg_valid_reg               <= 1'b0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);

            // Configuration writes; unknown indexes are ignored.
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TARGET_DUTY: cfg_reg.target_duty         <= cfg_data;
                    CFG_DUTY_MIN:    cfg_reg.duty_min            <= cfg_data;
                    CFG_DUTY_MAX:    cfg_reg.duty_max            <= cfg_data;
                    CFG_THR_LOW:     cfg_reg.duty_threshold_low  <= cfg_data;
                    CFG_THR_MID:     cfg_reg.duty_threshold_mid  <= cfg_data;
                    CFG_THR_HIGH:    cfg_reg.duty_threshold_high <= cfg_data;
                    CFG_LOW_TICKS:   cfg_reg.low_step_ticks      <= cfg_data;
                    CFG_HIGH_TICKS:  cfg_reg.high_step_ticks     <= cfg_data;
                    default:         ;
                endcase
            end

            // Interval sample: direct estimate until the first average exists.
            if (iv_take)
            begin
                if (avg_due)
                begin
                    avg_valid_reg <= 1'b1;
                    sum_reg       <= '0;
                    count_reg     <= '0;
                end
                else
                begin
                    sum_reg   <= sum_new;
                    count_reg <= count_new;
                    if (!avg_valid_reg)
                    begin
                        period_reg <= in_data.interval;
                    end
                end
            end

            // Control tick: duty ramp.
            if (tick_take)
            begin
                duty_reg <= ramp_duty;
                tick_reg <= ramp_tick;
            end

            // Six-sample average lands in the period estimate.
            if (div_take && !op_reg)
            begin
                period_reg <= div_quot[DUTY_W-1:0];
            end

            // Low-pass filter update, floor rounding by arithmetic shift.
            if (state_reg == ST_FILT_ADD)
            begin
                acc_reg <= acc_reg + delta;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= in_data.op;
        end

        if (tick_take && (period_reg == '0))
        begin
            raw_reg <= '1;
        end
        else if (div_take && op_reg)
        begin
            raw_reg <= (div_quot > DIV_NUM_W'((2 ** DUTY_W) - 1)) ? '1
                                                                  : div_quot[DUTY_W-1:0];
        end

        if (state_reg == ST_FILT_MUL)
        begin
            prod_reg <= PROD_W'(diff) * PROD_W'(signed'(GAIN_W'(FILTER_GAIN_Q10)));
        end

        if (out_load)
        begin
            out_data_reg.duty_out        <= duty_reg;
            out_data_reg.filtered_speed  <= acc_reg[ACC_FRAC +: DUTY_W];
            out_data_reg.period_estimate <= period_reg;
            out_data_reg.average_ready   <= avg_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The divider only runs while the sequencer waits for it.
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide state");

    // The sample counter restarts at each completed group.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(AVG_SAMPLES))
        else $error("sample count reached the group size");

    // Once an average exists it stays.
    a_avg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        avg_valid_reg |=> avg_valid_reg)
        else $error("average ready flag dropped");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("request accepted without starting work");

endmodule

`default_nettype wire

/* dv/bldc_open_loop_duty_ramp_core_tb.sv */
`timescale 1ns / 100ps

module bldc_open_loop_duty_ramp_core_tb;
    import bldc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEM_GOAL     = 1450;
    localparam int QUIET_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam logic [DUTY_W-1:0] DUTY_FULL = '1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DUTY_W-1:0]     cfg_data  = '0;

    // Register copy, starting from the reset values.
    cfg_t regs_now = '{
        target_duty:         '0,
        duty_min:            '0,
        duty_max:            DUTY_FULL,
        duty_threshold_low:  '0,
        duty_threshold_mid:  '0,
        duty_threshold_high: DUTY_FULL,
        low_step_ticks:      '0,
        high_step_ticks:     '0
    };

    // Predicted state of the speed and duty path.
    logic [DUTY_W-1:0] duty_now   = '0;
    logic [DUTY_W-1:0] duty_tick  = '0;
    logic [DUTY_W-1:0] period_now = '0;
    logic [ACC_W-1:0]  spd_acc    = '0;
    logic [SUM_W-1:0]  ivl_sum    = '0;
    logic [CNT_W-1:0]  ivl_cnt    = '0;
    logic              avg_ready  = 1'b0;

    in_item_t  requests_to_send[$];
    out_item_t duty_reports_due[$];

    int  requests_issued = 0;
    int  reports_checked = 0;
    int  mismatches      = 0;
    int  cycle_cnt       = 0;
    int  interval_cnt    = 0;
    int  tick_cnt        = 0;
    int  settings_cnt    = 0;
    int  duty_peak       = 0;
    bit  send_gaps_on    = 1'b0;
    bit  recv_gaps_on    = 1'b0;

    bldc_open_loop_duty_ramp_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Apply one request to the predicted state and return the report it produces.
    function automatic out_item_t next_duty_report(in_item_t req);
        out_item_t         rpt;
        int                nd;
        int                step;
        logic [DUTY_W-1:0] gate_ticks;
        logic [DUTY_W-1:0] raw;
        longint            diff;
        longint            prod;

        if (req.op)
        begin
            // The tick counter advances first and wraps at 16 bits.
            duty_tick = duty_tick + 1'b1;
            nd = int'(duty_now);
            if (duty_now < regs_now.duty_min)
            begin
                // Start-up climb below the minimum duty, without the clamp.
                if (duty_tick > regs_now.low_step_ticks)
                begin
                    duty_tick = '0;
                    nd = nd + STEP_SMALL;
                    duty_now = (nd > int'(DUTY_FULL)) ? DUTY_FULL : DUTY_W'(nd);
                end
            end
            else
            begin
                if (duty_now < regs_now.target_duty)
                begin
                    // The step size and its gate depend on the duty band.
                    if (duty_now <= regs_now.duty_threshold_low)
                    begin
                        gate_ticks = regs_now.low_step_ticks;
                        step = STEP_SMALL;
                    end
                    else if (duty_now > regs_now.duty_threshold_mid &&
                             duty_now < regs_now.duty_threshold_high)
                    begin
                        gate_ticks = regs_now.high_step_ticks;
                        step = STEP_MID;
                    end
                    else
                    begin
                        gate_ticks = regs_now.high_step_ticks;
                        step = STEP_LARGE;
                    end
                    if (duty_tick > gate_ticks)
                    begin
                        duty_tick = '0;
                        nd = nd + step;
                    end
                end
                else
                begin
                    duty_tick = '0;
                    nd = nd - STEP_MID;
                end
                // The minimum test comes first, so it wins over the maximum.
                if (nd <= int'(regs_now.duty_min))
                    duty_now = regs_now.duty_min;
                else if (nd >= int'(regs_now.duty_max))
                    duty_now = regs_now.duty_max;
                else
                    duty_now = DUTY_W'(nd);
            end

            // Speed from the period, saturating for a zero or very short period.
            if (period_now == '0)
                raw = DUTY_FULL;
            else if ((longint'(SPEED_SCALE) / longint'(period_now)) > longint'(DUTY_FULL))
                raw = DUTY_FULL;
            else
                raw = DUTY_W'(longint'(SPEED_SCALE) / longint'(period_now));

            // First-order filter; the arithmetic shift rounds toward minus infinity.
            diff = (longint'(raw) <<< ACC_FRAC) - longint'(spd_acc);
            prod = diff * FILTER_GAIN_Q10;
            spd_acc = ACC_W'(longint'(spd_acc) + (prod >>> ACC_FRAC));
        end
        else
        begin
            // Raw intervals drive the estimate until the first group average exists.
            if (!avg_ready)
                period_now = req.interval;
            ivl_sum = ivl_sum + req.interval;
            ivl_cnt = ivl_cnt + 1'b1;
            if (ivl_cnt >= AVG_SAMPLES)
            begin
                avg_ready = 1'b1;
                period_now = DUTY_W'(ivl_sum / AVG_SAMPLES);
                ivl_sum = '0;
                ivl_cnt = '0;
            end
        end

        rpt.duty_out        = duty_now;
        rpt.filtered_speed  = DUTY_W'(spd_acc >> ACC_FRAC);
        rpt.period_estimate = period_now;
        rpt.average_ready   = avg_ready;
        return rpt;
    endfunction

    // A register value near the given center, with the two extremes mixed in.
    function automatic logic [DUTY_W-1:0] pick_near(int center, int span);
        int v;

        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = int'(DUTY_FULL);
            default: v = center + int'($urandom_range(0, 2 * span)) - span;
        endcase
        if (v < 0)
            v = 0;
        else if (v > int'(DUTY_FULL))
            v = int'(DUTY_FULL);
        return DUTY_W'(v);
    endfunction

    // Step gates are mostly short so that the ramp moves; a few are long.
    function automatic logic [DUTY_W-1:0] pick_gate();
        if ($urandom_range(0, 9) == 0)
            return DUTY_W'($urandom_range(0, int'(DUTY_FULL)));
        return DUTY_W'($urandom_range(0, 3));
    endfunction

    // Mostly intervals near the current commutation period, with some outliers.
    function automatic in_item_t random_request(int base);
        in_item_t req;
        int       v;

        req.op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 15));
            1: v = int'($urandom_range(int'(DUTY_FULL) - 15, int'(DUTY_FULL)));
            2: v = int'($urandom_range(0, int'(DUTY_FULL)));
            default: v = base + int'($urandom_range(0, base / 8 + 2)) - (base / 16 + 1);
        endcase
        if (v < 0)
            v = 0;
        else if (v > int'(DUTY_FULL))
            v = int'(DUTY_FULL);
        req.interval = DUTY_W'(v);
        return req;
    endfunction

    task automatic queue_request(logic op, logic [DUTY_W-1:0] interval);
        in_item_t req;

        req.op = op;
        req.interval = interval;
        requests_to_send.push_back(req);
        requests_issued++;
    endtask

    // One register write; the block samples it at the following rising edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_TARGET_DUTY: regs_now.target_duty         = value;
            CFG_DUTY_MIN:    regs_now.duty_min            = value;
            CFG_DUTY_MAX:    regs_now.duty_max            = value;
            CFG_THR_LOW:     regs_now.duty_threshold_low  = value;
            CFG_THR_MID:     regs_now.duty_threshold_mid  = value;
            CFG_THR_HIGH:    regs_now.duty_threshold_high = value;
            CFG_LOW_TICKS:   regs_now.low_step_ticks      = value;
            CFG_HIGH_TICKS:  regs_now.high_step_ticks     = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A write to an index past the last register, which must change nothing.
    task automatic write_unused_reg();
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_HIGH_TICKS) + 1, (1 << CFG_IDX_W) - 1)),
                  DUTY_W'($urandom));
    endtask

    // Thresholds and limits placed around the present duty so every band is visited.
    task automatic program_random_setting();
        int d;

        d = int'(duty_now);
        write_reg(CFG_TARGET_DUTY, pick_near(d, 300));
        write_reg(CFG_DUTY_MIN, pick_near(d - 20, 60));
        write_reg(CFG_DUTY_MAX, pick_near(d + 200, 300));
        write_reg(CFG_THR_LOW, pick_near(d, 100));
        write_reg(CFG_THR_MID, pick_near(d, 100));
        write_reg(CFG_THR_HIGH, pick_near(d + 100, 150));
        write_reg(CFG_LOW_TICKS, pick_gate());
        write_reg(CFG_HIGH_TICKS, pick_gate());
        if ($urandom_range(0, 3) == 0)
            write_unused_reg();
        settings_cnt++;
    endtask

    // Hold off until every issued request has its report checked.
    task automatic wait_idle();
        while (reports_checked != requests_issued)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Request driver: holds a stalled request, otherwise inserts random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        int        send_left;
        out_item_t rpt;

        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                rpt = next_duty_report(in_data);
                duty_reports_due.push_back(rpt);
                if (in_data.op)
                    tick_cnt++;
                else
                    interval_cnt++;
                if (int'(rpt.duty_out) > duty_peak)
                    duty_peak = int'(rpt.duty_out);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_left != 0)
                begin
                    send_left--;
                    in_valid <= 1'b0;
                end
                else if (send_gaps_on && $urandom_range(0, 3) == 0)
                begin
                    send_left = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else if (requests_to_send.size() != 0)
                begin
                    in_data  <= requests_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted report and applies random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int        stall_left;
        out_item_t want;

        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (duty_reports_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: report with nothing pending: duty %0d speed %0d period %0d ready %0b",
                                 $time, out_data.duty_out, out_data.filtered_speed,
                                 out_data.period_estimate, out_data.average_ready);
                end
                else
                begin
                    want = duty_reports_due.pop_front();
                    reports_checked++;
                    if (out_data.duty_out !== want.duty_out ||
                        out_data.filtered_speed !== want.filtered_speed ||
                        out_data.period_estimate !== want.period_estimate ||
                        out_data.average_ready !== want.average_ready)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: report %0d expected duty %0d speed %0d period %0d ready %0b",
                                     $time, reports_checked, want.duty_out, want.filtered_speed,
                                     want.period_estimate, want.average_ready);
                            $display("%0t: report %0d actual   duty %0d speed %0d period %0d ready %0b",
                                     $time, reports_checked, out_data.duty_out,
                                     out_data.filtered_speed, out_data.period_estimate,
                                     out_data.average_ready);
                        end
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gaps_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d of %0d reports checked.",
                     cycle_cnt, reports_checked, requests_issued);
            $display("FAIL bldc_open_loop_duty_ramp_core");
            $finish;
        end
    end

    // Stimulus sequence: directed requests, then random phases, then a quiet tail.
    initial
    begin
        int base;
        int phase_len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero period, extreme intervals, first group average.
        @(negedge clk);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        queue_request(1'b1, '0);
        queue_request(1'b0, DUTY_FULL);
        queue_request(1'b1, DUTY_FULL);
        queue_request(1'b0, '0);
        queue_request(1'b1, '0);
        queue_request(1'b0, DUTY_W'(1));
        queue_request(1'b1, '0);
        repeat (3) queue_request(1'b0, DUTY_FULL);
        queue_request(1'b1, DUTY_FULL);
        queue_request(1'b0, DUTY_W'(15));
        queue_request(1'b1, '0);

        // Minimum above maximum: the duty keeps bouncing back into start-up.
        wait_idle();
        write_reg(CFG_TARGET_DUTY, DUTY_W'(20));
        write_reg(CFG_DUTY_MIN, DUTY_W'(6));
        write_reg(CFG_DUTY_MAX, DUTY_W'(3));
        write_reg(CFG_THR_LOW, DUTY_W'(2));
        write_reg(CFG_THR_MID, DUTY_W'(10));
        write_reg(CFG_THR_HIGH, DUTY_W'(15));
        write_reg(CFG_LOW_TICKS, '0);
        write_reg(CFG_HIGH_TICKS, '0);
        write_unused_reg();
        settings_cnt++;
        @(negedge clk);
        repeat (10) queue_request(1'b1, DUTY_W'($urandom));

        // Random phases, each under a fresh register setting.
        while (requests_issued < ITEM_GOAL - QUIET_ITEMS)
        begin
            wait_idle();
            if (settings_cnt == 1)
            begin
                for (int r = CFG_TARGET_DUTY; r <= CFG_HIGH_TICKS; r++)
                    write_reg(CFG_IDX_W'(r), DUTY_FULL);
                settings_cnt++;
            end
            else if (settings_cnt == 2)
            begin
                for (int r = CFG_TARGET_DUTY; r <= CFG_HIGH_TICKS; r++)
                    write_reg(CFG_IDX_W'(r), '0);
                settings_cnt++;
            end
            else
            begin
                program_random_setting();
            end
            @(negedge clk);
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: base = $urandom_range(0, 20);
                1: base = $urandom_range(21, 200);
                2: base = $urandom_range(201, 5000);
                default: base = $urandom_range(5001, int'(DUTY_FULL));
            endcase
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) requests_to_send.push_back(random_request(base));
            requests_issued += phase_len;
        end

        // Closing stretch with neither side idling.
        wait_idle();
        program_random_setting();
        @(negedge clk);
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        base = $urandom_range(100, 3000);
        repeat (QUIET_ITEMS) requests_to_send.push_back(random_request(base));
        requests_issued += QUIET_ITEMS;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (duty_reports_due.size() != 0)
        begin
            mismatches++;
            $display("%0d expected reports never arrived.", duty_reports_due.size());
        end

        $display("Checked %0d reports from %0d interval and %0d tick requests under %0d settings.",
                 reports_checked, interval_cnt, tick_cnt, settings_cnt);
        $display("Highest duty reached %0d; %0d mismatching reports.", duty_peak, mismatches);
        if (mismatches == 0)
            $display("PASS bldc_open_loop_duty_ramp_core");
        else
            $display("FAIL bldc_open_loop_duty_ramp_core");
        $finish;
    end

endmodule

/* sim.f */
hdl/bldc_pkg.sv
hdl/bldc_div.sv
hdl/bldc_ramp.sv
hdl/bldc_open_loop_duty_ramp_core.sv
dv/bldc_open_loop_duty_ramp_core_tb.sv
